### design/rmab_pkg.sv
// Package for the RGB565 masked alpha blend core.
// Holds register indexes, blend constants and shared widths; no dependencies.
`default_nettype none
package rmab_pkg;

	localparam int unsigned PIX_W = 16;
	localparam int unsigned MASK_W = 8;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [7:0] FULL_COVER_LEVEL = 8'd253;
	localparam logic [7:0] COVER = 8'hFF;
	localparam logic [31:0] SPREAD_MASK = 32'h07E0F81F;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FILL_COLOR = 2'd0,
		CFG_OPACITY    = 2'd1,
		CFG_BYTE_SWAP  = 2'd2
	} cfg_idx_t;

	typedef logic [PIX_W-1:0] pixel_t;

endpackage
`default_nettype wire

### design/rmab_if.sv
// Stream interfaces for the RGB565 masked alpha blend core.
// Depends on rmab_pkg for the pixel and mask widths.
`default_nettype none
interface rmab_in_if;
	import rmab_pkg::*;
	logic                 valid;
	logic                 ready;
	logic                 command;
	logic [PIX_W-1:0]     source_pixel;
	logic [PIX_W-1:0]     dest_pixel;
	logic [MASK_W-1:0]    mask_value;
	logic                 mask_present;

	modport source (output valid, command, source_pixel, dest_pixel, mask_value,
		mask_present, input ready);
	modport sink (input valid, command, source_pixel, dest_pixel, mask_value,
		mask_present, output ready);
endinterface

interface rmab_out_if;
	import rmab_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [PIX_W-1:0]     result_pixel;
	logic                 pixel_written;

	modport source (output valid, result_pixel, pixel_written, input ready);
	modport sink (input valid, result_pixel, pixel_written, output ready);
endinterface
`default_nettype wire

### design/rgb565_masked_alpha_blend_core.sv
// Top level of the RGB565 masked alpha blend core: four-stage blend pipeline.
// Depends on rmab_pkg and the stream interfaces in rmab_if.sv.
//
// The core accepts one pixel transaction per clock while the output is not
// stalled and returns one result per transaction, in order. Stage one
// registers the operands and the 8x8 mask-by-opacity product, stage two
// forms the effective opacity and the spread channel difference, stage
// three holds the 32x6 channel-weight product, and stage four holds the
// folded, byte-ordered result. The whole pipeline advances whenever the
// output stage is empty or its result is taken, so a stall holds every
// stage in place. Configuration writes take effect at once and are meant to
// happen only while no transaction is in flight.
`default_nettype none
module rgb565_masked_alpha_blend_core
	import rmab_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  wr_en,
	input  wire logic [CFG_IDX_W-1:0]  wr_index,
	input  wire logic [CFG_DATA_W-1:0] wr_data,
	rmab_in_if.sink                    pixel_in,
	rmab_out_if.source                 pixel_out
);

	pixel_t     fill_color_q;
	logic [7:0] opacity_q;
	logic       byte_swap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_color_q <= '0;
			opacity_q    <= 8'hFF;
			byte_swap_q  <= 1'b0;
		end else if (wr_en) begin
			case (cfg_idx_t'(wr_index))
				CFG_FILL_COLOR: fill_color_q <= wr_data[15:0];
				CFG_OPACITY:    opacity_q    <= wr_data[7:0];
				CFG_BYTE_SWAP:  byte_swap_q  <= wr_data[0];
				default: ;
			endcase
		end
	end

	function automatic pixel_t swap_bytes(input pixel_t p, input logic en);
		swap_bytes = en ? {p[7:0], p[15:8]} : p;
	endfunction

	logic advance;
	logic v_s1, v_s2, v_s3, v_s4;

	assign advance        = !v_s4 || pixel_out.ready;
	assign pixel_in.ready = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (advance) begin
			v_s1 <= pixel_in.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Stage one: operand capture and mask-by-opacity product.
	logic        cmd_s1, use_mask_s1;
	pixel_t      fg_s1, dst_s1;
	logic [7:0]  mask_s1;
	logic [15:0] prod_s1;

	always_ff @(posedge clk) begin
		if (advance) begin
			cmd_s1      <= pixel_in.command;
			use_mask_s1 <= !pixel_in.command || pixel_in.mask_present;
			fg_s1       <= pixel_in.command ? pixel_in.source_pixel : fill_color_q;
			dst_s1      <= pixel_in.dest_pixel;
			mask_s1     <= pixel_in.mask_value;
			prod_s1     <= 16'(pixel_in.mask_value) * 16'(opacity_q);
		end
	end

	// Stage two: effective opacity, weight and spread difference.
	logic [7:0]  eff_c;
	logic [8:0]  wsum_c;
	logic [31:0] fg_sp_c, bg_sp_c;
	logic        written_s2, full_s2;
	logic [5:0]  w_s2;
	logic [31:0] diff_s2, bg_s2;
	pixel_t      fg_s2, dst_s2;

	always_comb begin
		if (!use_mask_s1)
			eff_c = opacity_q;
		else if (!cmd_s1 && opacity_q >= FULL_COVER_LEVEL)
			eff_c = mask_s1;
		else if (mask_s1 == COVER)
			eff_c = opacity_q;
		else
			eff_c = prod_s1[15:8];
		wsum_c  = 9'(eff_c) + 9'd4;
		fg_sp_c = {2{swap_bytes(fg_s1, byte_swap_q)}} & SPREAD_MASK;
		bg_sp_c = {2{swap_bytes(dst_s1, byte_swap_q)}} & SPREAD_MASK;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			written_s2 <= !(use_mask_s1 && mask_s1 == 8'd0);
			full_s2    <= eff_c == COVER;
			w_s2       <= wsum_c[8:3];
			diff_s2    <= fg_sp_c - bg_sp_c;
			bg_s2      <= bg_sp_c;
			fg_s2      <= fg_s1;
			dst_s2     <= dst_s1;
		end
	end

	// Stage three: channel-weight product.
	logic        written_s3, full_s3;
	logic [5:0]  w_s3;
	logic [31:0] mul_s3, bg_s3;
	pixel_t      fg_s3, dst_s3;

	always_ff @(posedge clk) begin
		if (advance) begin
			written_s3 <= written_s2;
			full_s3    <= full_s2;
			w_s3       <= w_s2;
			mul_s3     <= diff_s2 * 32'(w_s2);
			bg_s3      <= bg_s2;
			fg_s3      <= fg_s2;
			dst_s3     <= dst_s2;
		end
	end

	// Stage four: rescale, fold and restore byte order, or pass the destination or foreground through.
	logic [31:0] mix_c;
	pixel_t      fold_c;
	pixel_t      result_s4, dst_s4;
	logic        written_s4;

	always_comb begin
		mix_c  = ((mul_s3 >> 5) + bg_s3) & SPREAD_MASK;
		fold_c = mix_c[31:16] | mix_c[15:0];
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			written_s4 <= written_s3;
			dst_s4     <= dst_s3;
			if (!written_s3)
				result_s4 <= dst_s3;
			else if (full_s3)
				result_s4 <= fg_s3;
			else
				result_s4 <= swap_bytes(fold_c, byte_swap_q);
		end
	end

	assign pixel_out.valid         = v_s4;
	assign pixel_out.result_pixel  = result_s4;
	assign pixel_out.pixel_written = written_s4;

`ifndef NO_ASSERTIONS
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && !pixel_out.ready |=> v_s4 && $stable(result_s4) && $stable(written_s4))
		else $error("stalled result changed");

	a_unwritten_is_dest: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && !written_s4 |-> result_s4 == dst_s4)
		else $error("unwritten pixel differs from destination");

	a_no_loss: assert property (@(posedge clk) disable iff (!arst_n)
		advance && v_s3 |=> v_s4)
		else $error("stage three transaction lost");

	a_weight_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> w_s3 <= 6'd32)
		else $error("mix weight out of range");
`endif

endmodule
`default_nettype wire
